>>> hw/rtl/bounded_ordered_list_engine_unit_defines.svh
// assertion macros used by the list engine checker
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BOLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define BOLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bole_pkg.sv
// shared types, codes and helpers of the ordered list engine
package bole_pkg;

	// slot store geometry
	localparam int SLOTS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// fixed field widths
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	localparam int POS_W = 4;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam int OCNT_W = 5;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// most results one read-out gives
	localparam int MAX_RESULTS = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// request codes
	localparam func_t FN_ADD_HEAD = 3'd0;
	localparam func_t FN_ADD_TAIL = 3'd1;
	localparam func_t FN_INSERT = 3'd2;
	localparam func_t FN_DELETE = 3'd3;
	localparam func_t FN_SEARCH = 3'd4;
	localparam func_t FN_READ_OUT = 3'd5;

	// status codes
	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_MISSING = 2'd3;

	// write commands into the slot store
	typedef struct packed {
		logic en;
		slot_t addr;
		data_t data;
	} val_wr_t;

	typedef struct packed {
		logic en;
		slot_t addr;
		slot_t data;
	} lnk_wr_t;

	// lowest free slot of the free map
	function automatic slot_t first_free(input logic [SLOTS-1:0] map);
		slot_t s;
		s = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (map[i]) begin
				s = slot_t'(i);
			end
		end
		return s;
	endfunction

endpackage

>>> hw/rtl/bole_if.sv
// channel interfaces: request, result and capacity write
interface bole_req_if;
	import bole_pkg::*;
	logic valid;
	logic ready;
	func_t func;
	data_t value;
	data_t match_key;
	modport source(output valid, output func, output value, output match_key, input ready);
	modport sink(input valid, input func, input value, input match_key, output ready);
endinterface

interface bole_rsp_if;
	import bole_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	logic [POS_W-1:0] position;
	data_t entry_value;
	logic [OCNT_W-1:0] entry_count;
	logic last;
	modport source(output valid, output status, output position, output entry_value,
		output entry_count, output last, input ready);
	modport sink(input valid, input status, input position, input entry_value,
		input entry_count, input last, output ready);
endinterface

interface bole_cfg_if;
	import bole_pkg::*;
	logic valid;
	logic ready;
	logic [CAP_W-1:0] capacity;
	modport source(output valid, output capacity, input ready);
	modport sink(input valid, input capacity, output ready);
endinterface

>>> hw/rtl/bole_store.sv
// slot store: values and next links, one read port with registered data
module bole_store (
	input logic clk,
	input bole_pkg::slot_t rd_addr,
	input bole_pkg::val_wr_t val_wr,
	input bole_pkg::lnk_wr_t lnk_wr,
	output bole_pkg::data_t rd_value,
	output bole_pkg::slot_t rd_link
);
	import bole_pkg::*;

	data_t value_mem [SLOTS];
	slot_t link_mem [SLOTS];

	// value memory
	always_ff @(posedge clk) begin
		if (val_wr.en) begin
			value_mem[val_wr.addr] <= val_wr.data;
		end
		rd_value <= value_mem[rd_addr];
	end

	// link memory
	always_ff @(posedge clk) begin
		if (lnk_wr.en) begin
			link_mem[lnk_wr.addr] <= lnk_wr.data;
		end
		rd_link <= link_mem[rd_addr];
	end

endmodule

>>> hw/rtl/bounded_ordered_list_engine_unit.sv
// top level of the bounded ordered list engine
//
//   channel  dir  payload                                          handshake
//   req      in   func, value, match_key                           valid/ready
//   rsp      out  status, position, entry_value, entry_count, last valid/ready
//   cfg      in   capacity                                         valid/ready
//
// add tail and insert then link the preceding slot to the new slot in a fix step
// insert, delete and search walk the list entry by entry from the head to a hit or the end
// read out gives one result beat per entry, each result waits on a free output register
// the link walk goes through the single read port of the slot store
// reset empties the list and sets capacity to 16; req is refused while busy
// a stalled rsp holds the beat; the next request is taken meanwhile
module bounded_ordered_list_engine_unit (
	input logic clk,
	input logic arst_n,
	bole_req_if.sink req,
	bole_rsp_if.source rsp,
	bole_cfg_if.sink cfg
);
	import bole_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_FIX = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	func_t func_q;
	data_t value_q;
	data_t key_q;
	slot_t idx_q;
	slot_t cur_q;
	slot_t prev_q;
	slot_t head_q;
	slot_t tail_q;
	slot_t fix_slot_q;
	slot_t fix_new_q;
	logic [CNT_W-1:0] used_q;
	logic [SLOTS-1:0] free_q;
	logic [CAP_W-1:0] capacity_q;
	status_t res_status_q;
	logic [POS_W-1:0] res_pos_q;

	logic out_valid_q;
	status_t out_status_q;
	logic [POS_W-1:0] out_pos_q;
	data_t out_value_q;
	logic [OCNT_W-1:0] out_count_q;
	logic out_last_q;

	slot_t rd_addr;
	data_t rd_value;
	slot_t rd_link;
	val_wr_t val_wr;
	lnk_wr_t lnk_wr;

	logic accept;
	logic out_free;
	logic [CMP_W-1:0] eff_cap;
	logic is_full;
	logic is_empty;
	logic is_add;
	logic is_keyed;
	logic acc_full;
	logic acc_empty;
	logic acc_add;
	logic acc_walk;
	logic acc_read;
	slot_t new_slot;
	logic [CNT_W-1:0] idx_nxt;
	logic hit;
	logic walk_end;
	logic wk_ins;
	logic wk_del;
	logic read_adv;
	logic read_last;

	// handshakes
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || rsp.ready;

	// request classification at accept
	assign eff_cap = (CMP_W'(capacity_q) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(capacity_q);
	assign is_full = CMP_W'(used_q) >= eff_cap;
	assign is_empty = (used_q == '0);
	assign is_add = (req.func == FN_ADD_HEAD) || (req.func == FN_ADD_TAIL);
	assign is_keyed = (req.func == FN_INSERT) || (req.func == FN_DELETE) ||
		(req.func == FN_SEARCH);
	assign acc_full = accept && (is_add || req.func == FN_INSERT) && is_full;
	assign acc_empty = accept && !acc_full && (is_keyed || req.func == FN_READ_OUT) &&
		is_empty;
	assign acc_add = accept && is_add && !is_full;
	assign acc_walk = accept && is_keyed && !acc_full && !is_empty;
	assign acc_read = accept && (req.func == FN_READ_OUT) && !is_empty;
	assign new_slot = first_free(free_q);

	// walk step: data of cur_q sits in the store output
	assign idx_nxt = CNT_W'(idx_q) + CNT_W'(1);
	assign hit = (rd_value == key_q);
	assign walk_end = (idx_nxt == used_q);
	assign wk_ins = (state_q == S_WALK) && hit && (func_q == FN_INSERT);
	assign wk_del = (state_q == S_WALK) && hit && (func_q == FN_DELETE);
	assign read_adv = (state_q == S_READ) && out_free;
	assign read_last = walk_end || (CMP_W'(idx_q) == CMP_W'(MAX_RESULTS - 1));

	// store read address
	always_comb begin
		case (state_q)
			S_IDLE: rd_addr = head_q;
			S_WALK: rd_addr = rd_link;
			S_READ: rd_addr = read_adv ? rd_link : cur_q;
			default: rd_addr = cur_q;
		endcase
	end

	// store write commands, at most one per memory each cycle
	always_comb begin
		val_wr.en = acc_add || wk_ins;
		val_wr.addr = new_slot;
		val_wr.data = acc_add ? req.value : value_q;
		lnk_wr.en = 1'b0;
		lnk_wr.addr = new_slot;
		lnk_wr.data = '0;
		if (acc_add) begin
			lnk_wr.en = 1'b1;
			lnk_wr.data = (req.func == FN_ADD_HEAD && !is_empty) ? head_q : '0;
		end else if (wk_ins) begin
			lnk_wr.en = 1'b1;
			lnk_wr.data = rd_link;
		end else if (wk_del && idx_q != '0) begin
			lnk_wr.en = 1'b1;
			lnk_wr.addr = prev_q;
			lnk_wr.data = rd_link;
		end else if (state_q == S_FIX) begin
			lnk_wr.en = 1'b1;
			lnk_wr.addr = fix_slot_q;
			lnk_wr.data = fix_new_q;
		end
	end

	bole_store u_store (
		.clk(clk),
		.rd_addr(rd_addr),
		.val_wr(val_wr),
		.lnk_wr(lnk_wr),
		.rd_value(rd_value),
		.rd_link(rd_link)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.capacity;
		end
	end

	// request payload and walk tracking
	always_ff @(posedge clk) begin
		cur_q <= rd_addr;
		if (accept) begin
			func_q <= req.func;
			value_q <= req.value;
			key_q <= req.match_key;
		end
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			free_q <= '1;
			idx_q <= '0;
			prev_q <= '0;
			fix_slot_q <= '0;
			fix_new_q <= '0;
			res_status_q <= ST_OK;
			res_pos_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						prev_q <= head_q;
						res_status_q <= ST_OK;
						res_pos_q <= '0;
						state_q <= S_DONE;
						if (acc_full) begin
							res_status_q <= ST_FULL;
						end else if (acc_empty) begin
							res_status_q <= ST_EMPTY;
						end else if (acc_add) begin
							free_q[new_slot] <= 1'b0;
							used_q <= used_q + CNT_W'(1);
							if (is_empty) begin
								head_q <= new_slot;
								tail_q <= new_slot;
							end else if (req.func == FN_ADD_HEAD) begin
								head_q <= new_slot;
							end else begin
								fix_slot_q <= tail_q;
								fix_new_q <= new_slot;
								tail_q <= new_slot;
								state_q <= S_FIX;
							end
						end else if (acc_walk) begin
							state_q <= S_WALK;
						end else if (acc_read) begin
							state_q <= S_READ;
						end
					end
				end
				S_WALK: begin
					if (hit) begin
						res_status_q <= ST_OK;
						res_pos_q <= POS_W'(idx_q);
						state_q <= S_DONE;
						case (func_q)
							FN_INSERT: begin
								free_q[new_slot] <= 1'b0;
								used_q <= used_q + CNT_W'(1);
								if (cur_q == tail_q) begin
									tail_q <= new_slot;
								end
								fix_slot_q <= cur_q;
								fix_new_q <= new_slot;
								state_q <= S_FIX;
							end
							FN_DELETE: begin
								free_q[cur_q] <= 1'b1;
								used_q <= used_q - CNT_W'(1);
								if (used_q == CNT_W'(1)) begin
									head_q <= '0;
									tail_q <= '0;
								end else if (idx_q == '0) begin
									head_q <= rd_link;
								end else if (cur_q == tail_q) begin
									tail_q <= prev_q;
								end
							end
							default: begin
							end
						endcase
					end else if (walk_end) begin
						res_status_q <= ST_MISSING;
						res_pos_q <= '0;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
						prev_q <= cur_q;
					end
				end
				S_READ: begin
					if (out_free) begin
						if (read_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + SLOT_W'(1);
						end
					end
				end
				S_FIX: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE || state_q == S_READ) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_pos_q <= res_pos_q;
			out_value_q <= '0;
			out_count_q <= OCNT_W'(used_q);
			out_last_q <= 1'b1;
		end else if (read_adv) begin
			out_status_q <= ST_OK;
			out_pos_q <= POS_W'(idx_q);
			out_value_q <= rd_value;
			out_count_q <= OCNT_W'(used_q);
			out_last_q <= read_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.position = out_pos_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.last = out_last_q;

endmodule

>>> hw/rtl/bole_checker.sv
// port checker of the list engine and its bind to the top level
`include "bounded_ordered_list_engine_unit_defines.svh"

module bole_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input bole_pkg::status_t rsp_status,
	input logic [bole_pkg::POS_W-1:0] rsp_position,
	input bole_pkg::data_t rsp_entry_value,
	input logic [bole_pkg::OCNT_W-1:0] rsp_entry_count,
	input logic rsp_last
);
	import bole_pkg::*;

	// one request at a time: busy right after a request beat
	`BOLE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "req ready after accept")

	// a stalled result beat holds
	`BOLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_entry_value) && $stable(rsp_entry_count) && $stable(rsp_last), "rsp beat changed under stall")

	// an error is a single zeroed beat
	`BOLE_ASSERT_NOW(a_err_single, rsp_valid && rsp_status != ST_OK, rsp_last && rsp_position == '0 && rsp_entry_value == '0, "error beat not single")

	// only read-out gives beats before the last one
	`BOLE_ASSERT_NOW(a_mid_ok, rsp_valid && !rsp_last, rsp_status == ST_OK && rsp_entry_count != '0, "bad non-final beat")

endmodule

bind bounded_ordered_list_engine_unit bole_checker u_bole_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rsp_position(rsp.position),
	.rsp_entry_value(rsp.entry_value),
	.rsp_entry_count(rsp.entry_count),
	.rsp_last(rsp.last)
);
